>>> design/mau_pkg.sv
// shared constants for the modular arithmetic unit
// field widths, stream packing and operation codes; no dependencies
package mau_pkg;

    // field widths of the stream beats
    localparam int KIND_W  = 3;
    localparam int OPA_W   = 32;
    localparam int OPB_W   = 33;
    localparam int VALUE_W = 32;
    localparam int CFG_W   = 32;

    // operand a and operand b packed, padded to whole bytes
    localparam int TDATA_W = ((OPA_W + OPB_W + 7) / 8) * 8;

    // bit counter of the serial divider, able to hold OPB_W
    localparam int DIV_CNT_W = $clog2(OPB_W + 1);

    // modulus after reset
    localparam logic [CFG_W-1:0] MOD_RESET_VAL = 32'd1000000007;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
    localparam logic [KIND_W-1:0] KIND_POW = 3'd4;

endpackage

>>> design/modular_arithmetic_unit.sv
// modular arithmetic unit: add, subtract, multiply, divide and power modulo a register
// depends on mau_pkg; shared bit-serial divider and bit-serial modular multiplier
//
// Each input beat carries an operation in s_axis_tuser and two operands in s_axis_tdata and
// yields one output beat with the result reduced modulo the modulus register (written via
// cfg_we/cfg_data; the user must write it only while the unit is idle, as the unit does
// not enforce this). One item is processed at a time; a new item is taken while the
// previous result still waits in the output register. Timing is set by a restoring
// divider that retires one bit per cycle and a modular multiplier that retires one
// multiplier bit per cycle (it stops at the highest set bit). Add, subtract, multiply
// and divide first reduce both operands with the divider. Power reduces only operand a
// and then handles each exponent bit (at most 32) with a check state, a multiplication
// when the bit is set and, while higher bits remain, a squaring of the base. Divide runs
// extended Euclid, each step one division plus one multiplication, at most about 47
// steps for WIDTH 32, then one final multiplication. A zero modulus or an unknown
// operation code gives 0 without using the divider or multiplier.
module modular_arithmetic_unit #(
    parameter int WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // modulus register write
    input  logic                        cfg_we,
    input  logic [mau_pkg::CFG_W-1:0]   cfg_data,
    // input beats
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [mau_pkg::TDATA_W-1:0] s_axis_tdata,   // operand_a, operand_b, zero pad
    input  logic [mau_pkg::KIND_W-1:0]  s_axis_tuser,   // kind
    // output beats
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [mau_pkg::VALUE_W-1:0] m_axis_tdata    // value
);

    localparam int OPB_W = mau_pkg::OPB_W;
    localparam int CNT_W = mau_pkg::DIV_CNT_W;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_RED_A  = 11'b000_0000_0010,
        S_RED_B  = 11'b000_0000_0100,
        S_ALU    = 11'b000_0000_1000,
        S_EU_DIV = 11'b000_0001_0000,
        S_EU_MUL = 11'b000_0010_0000,
        S_MUL    = 11'b000_0100_0000,
        S_PW_CHK = 11'b000_1000_0000,
        S_PW_MUL = 11'b001_0000_0000,
        S_PW_SQR = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    // (x + y) mod m for x, y below m
    function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                                 input logic [WIDTH-1:0] y,
                                                 input logic [WIDTH-1:0] m);
        logic [WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[WIDTH-1:0];
    endfunction

    // (x - y) mod m for x, y below m
    function automatic logic [WIDTH-1:0] sub_mod(input logic [WIDTH-1:0] x,
                                                 input logic [WIDTH-1:0] y,
                                                 input logic [WIDTH-1:0] m);
        logic [WIDTH:0] d;
        if (x >= y)
        begin
            d = {1'b0, x} - {1'b0, y};
        end
        else
        begin
            d = {1'b0, x} + {1'b0, m} - {1'b0, y};
        end
        return d[WIDTH-1:0];
    endfunction

    // control registers
    state_t                      state_reg, state_next;
    logic                        out_valid_reg, out_valid_next;
    logic [WIDTH-1:0]            mod_reg, mod_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;

    // item registers
    logic [mau_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [WIDTH-1:0]            a_reg, a_next;        // reduced a, later power base
    logic [OPB_W-1:0]            b_reg, b_next;        // raw b, later exponent shifter
    logic [WIDTH-1:0]            br_reg, br_next;
    logic [WIDTH-1:0]            res_reg, res_next;
    logic [mau_pkg::VALUE_W-1:0] value_reg, value_next;

    // serial divider
    logic [OPB_W-1:0]            dvd_reg, dvd_next;    // dividend in, quotient out
    logic [WIDTH-1:0]            dsr_reg, dsr_next;
    logic [WIDTH-1:0]            rem_reg, rem_next;

    // serial modular multiplier
    logic [WIDTH-1:0]            acc_reg, acc_next;
    logic [WIDTH-1:0]            mcd_reg, mcd_next;    // multiplicand, doubled each bit
    logic [WIDTH-1:0]            mpl_reg, mpl_next;    // multiplier, shifted right

    // extended euclid
    logic [WIDTH-1:0]            val_reg, val_next;
    logic [WIDTH-1:0]            bb_reg, bb_next;
    logic [WIDTH-1:0]            u_reg, u_next;
    logic [WIDTH-1:0]            v_reg, v_next;

    logic                        in_fire;
    logic [WIDTH-1:0]            one_mod;
    logic [OPB_W-1:0]            b_mag;
    logic [WIDTH:0]              rem_sh;
    logic                        div_ge;
    logic [WIDTH:0]              rem_sub;
    logic [WIDTH-1:0]            div_rem_step;
    logic [WIDTH-1:0]            acc_step;
    logic [WIDTH-1:0]            mcd_step;
    logic                        div_busy;
    logic                        mul_busy;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = value_reg;

    // 1 mod m
    assign one_mod = (mod_reg == WIDTH'(1)) ? '0 : WIDTH'(1);

    // magnitude of the signed operand b
    assign b_mag = b_reg[OPB_W-1] ? (~b_reg + OPB_W'(1)) : b_reg;

    // one restoring division step
    assign rem_sh       = {rem_reg, dvd_reg[OPB_W-1]};
    assign div_ge       = (rem_sh >= {1'b0, dsr_reg});
    assign rem_sub      = rem_sh - {1'b0, dsr_reg};
    assign div_rem_step = div_ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
    assign div_busy     = (cnt_reg != '0);

    // one modular multiplication step, lsb first
    assign acc_step = mpl_reg[0] ? add_mod(acc_reg, mcd_reg, mod_reg) : acc_reg;
    assign mcd_step = add_mod(mcd_reg, mcd_reg, mod_reg);
    assign mul_busy = (mpl_reg != '0);

    // sequencer and datapath
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        mod_next       = cfg_we ? cfg_data[WIDTH-1:0] : mod_reg;
        cnt_next       = cnt_reg;
        kind_next      = kind_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        br_next        = br_reg;
        res_next       = res_reg;
        value_next     = value_reg;
        dvd_next       = dvd_reg;
        dsr_next       = dsr_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        mcd_next       = mcd_reg;
        mpl_next       = mpl_reg;
        val_next       = val_reg;
        bb_next        = bb_reg;
        u_next         = u_reg;
        v_next         = v_reg;

        // shared divider and multiplier steps
        if ((state_reg == S_RED_A || state_reg == S_RED_B || state_reg == S_EU_DIV) && div_busy)
        begin
            dvd_next = {dvd_reg[OPB_W-2:0], div_ge};
            rem_next = div_rem_step;
            cnt_next = cnt_reg - 1'b1;
        end
        if ((state_reg == S_MUL || state_reg == S_EU_MUL || state_reg == S_PW_MUL
             || state_reg == S_PW_SQR) && mul_busy)
        begin
            acc_next = acc_step;
            mcd_next = mcd_step;
            mpl_next = mpl_reg >> 1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    kind_next = s_axis_tuser;
                    a_next    = s_axis_tdata[WIDTH-1:0];
                    b_next    = s_axis_tdata[mau_pkg::OPA_W +: OPB_W];
                    dvd_next  = OPB_W'(s_axis_tdata[WIDTH-1:0]);
                    dsr_next  = mod_reg;
                    rem_next  = '0;
                    cnt_next  = CNT_W'(OPB_W);
                    if (mod_reg == '0 || s_axis_tuser > mau_pkg::KIND_POW)
                    begin
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RED_A;
                    end
                end
            end

            // a mod m
            S_RED_A:
            begin
                if (!div_busy)
                begin
                    a_next = rem_reg;
                    if (kind_reg == mau_pkg::KIND_POW)
                    begin
                        res_next = one_mod;
                        if (b_reg[OPB_W-1] || b_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_PW_CHK;
                        end
                    end
                    else
                    begin
                        dvd_next   = b_mag;
                        rem_next   = '0;
                        cnt_next   = CNT_W'(OPB_W);
                        state_next = S_RED_B;
                    end
                end
            end

            // |b| mod m, folded back for negative b
            S_RED_B:
            begin
                if (!div_busy)
                begin
                    br_next    = b_reg[OPB_W-1] ? sub_mod('0, rem_reg, mod_reg) : rem_reg;
                    state_next = S_ALU;
                end
            end

            S_ALU:
            begin
                case (kind_reg)
                    mau_pkg::KIND_ADD:
                    begin
                        res_next   = add_mod(a_reg, br_reg, mod_reg);
                        state_next = S_DONE;
                    end
                    mau_pkg::KIND_SUB:
                    begin
                        res_next   = sub_mod(a_reg, br_reg, mod_reg);
                        state_next = S_DONE;
                    end
                    mau_pkg::KIND_MUL:
                    begin
                        acc_next   = '0;
                        mcd_next   = br_reg;
                        mpl_next   = a_reg;
                        state_next = S_MUL;
                    end
                    mau_pkg::KIND_DIV:
                    begin
                        val_next   = br_reg;
                        bb_next    = mod_reg;
                        u_next     = one_mod;
                        v_next     = '0;
                        dvd_next   = OPB_W'(br_reg);
                        dsr_next   = mod_reg;
                        rem_next   = '0;
                        cnt_next   = CNT_W'(OPB_W);
                        state_next = S_EU_DIV;
                    end
                    default:
                    begin
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                endcase
            end

            // quotient t = val / bb, then t * v mod m
            S_EU_DIV:
            begin
                if (!div_busy)
                begin
                    acc_next   = '0;
                    mcd_next   = v_reg;
                    mpl_next   = dvd_reg[WIDTH-1:0];
                    state_next = S_EU_MUL;
                end
            end

            // u -= t * v, then swap the pairs
            S_EU_MUL:
            begin
                if (!mul_busy)
                begin
                    val_next = bb_reg;
                    bb_next  = rem_reg;
                    u_next   = v_reg;
                    v_next   = sub_mod(u_reg, acc_reg, mod_reg);
                    if (rem_reg == '0)
                    begin
                        acc_next   = '0;
                        mcd_next   = v_reg;
                        mpl_next   = a_reg;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        dvd_next   = OPB_W'(bb_reg);
                        dsr_next   = rem_reg;
                        rem_next   = '0;
                        cnt_next   = CNT_W'(OPB_W);
                        state_next = S_EU_DIV;
                    end
                end
            end

            S_MUL:
            begin
                if (!mul_busy)
                begin
                    res_next   = acc_reg;
                    state_next = S_DONE;
                end
            end

            // square-and-multiply, exponent lsb first
            S_PW_CHK:
            begin
                acc_next = '0;
                mcd_next = a_reg;
                if (b_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (b_reg[0])
                begin
                    mpl_next   = res_reg;
                    state_next = S_PW_MUL;
                end
                else
                begin
                    mpl_next   = a_reg;
                    state_next = S_PW_SQR;
                end
            end

            S_PW_MUL:
            begin
                if (!mul_busy)
                begin
                    res_next = acc_reg;
                    if (b_reg[OPB_W-1:1] == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        acc_next   = '0;
                        mcd_next   = a_reg;
                        mpl_next   = a_reg;
                        state_next = S_PW_SQR;
                    end
                end
            end

            S_PW_SQR:
            begin
                if (!mul_busy)
                begin
                    a_next     = acc_reg;
                    b_next     = b_reg >> 1;
                    state_next = S_PW_CHK;
                end
            end

            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    value_next     = mau_pkg::VALUE_W'(res_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            mod_reg       <= WIDTH'(mau_pkg::MOD_RESET_VAL);
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            mod_reg       <= mod_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        br_reg    <= br_next;
        res_reg   <= res_next;
        value_reg <= value_next;
        dvd_reg   <= dvd_next;
        dsr_reg   <= dsr_next;
        rem_reg   <= rem_next;
        acc_reg   <= acc_next;
        mcd_reg   <= mcd_next;
        mpl_reg   <= mpl_next;
        val_reg   <= val_next;
        bb_reg    <= bb_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
    end

`ifndef SYNTHESIS
    // accumulator and multiplicand stay reduced while the multiplier runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_EU_MUL || state_reg == S_PW_MUL
         || state_reg == S_PW_SQR) |-> (acc_reg < mod_reg && mcd_reg < mod_reg))
    else $error("multiplier operand not reduced");

    // divider remainder stays below a nonzero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RED_A || state_reg == S_RED_B || state_reg == S_EU_DIV)
        |-> (dsr_reg != '0 && rem_reg < dsr_reg))
    else $error("divider remainder out of range");

    // euclid coefficients stay reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EU_DIV || state_reg == S_EU_MUL)
        |-> (u_reg < mod_reg && v_reg < mod_reg))
    else $error("euclid coefficient not reduced");

    // a delivered result is below the modulus
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || m_axis_tready) && mod_reg != '0)
        |=> (m_axis_tdata < mau_pkg::VALUE_W'(mod_reg)))
    else $error("result not reduced");
`endif

endmodule

>>> bench/tb_top.sv
// self-checking bench for modular_arithmetic_unit: directed and random beats of all operations
// depends on mau_pkg and the unit under test; expected values come from a scoreboard class
module tb_top;

    localparam int KIND_W  = mau_pkg::KIND_W;
    localparam int OPA_W   = mau_pkg::OPA_W;
    localparam int OPB_W   = mau_pkg::OPB_W;
    localparam int VALUE_W = mau_pkg::VALUE_W;
    localparam int CFG_W   = mau_pkg::CFG_W;
    localparam int TDATA_W = mau_pkg::TDATA_W;

    // codes the unit treats as no operation
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
    localparam int STALL_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASES         = 9;
    localparam int PAD_W          = TDATA_W - OPA_W - OPB_W;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [OPA_W-1:0]   a;
        logic [OPB_W-1:0]   b;
        logic [VALUE_W-1:0] value;
    } op_record_t;

    // holds the modulus copy and the queue of expected values
    class residue_board;
        logic [CFG_W-1:0] modulus;
        op_record_t       expected_q[$];
        int               errors;

        function new();
            modulus = mau_pkg::MOD_RESET_VAL;
            errors  = 0;
        endfunction

        function void set_modulus(logic [CFG_W-1:0] m);
            modulus = m;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // extended euclid coefficient of x, brought into 0 .. m-1
        function longint inverse_coeff(longint x, longint m);
            longint val, bb, u, v, t, tmp;
            val = x;
            bb  = m;
            u   = 1;
            v   = 0;
            while (bb != 0)
            begin
                t   = val / bb;
                val = val - t * bb;
                tmp = val;
                val = bb;
                bb  = tmp;
                u   = u - t * v;
                tmp = u;
                u   = v;
                v   = tmp;
            end
            u = u % m;
            if (u < 0)
                u = u + m;
            return u;
        endfunction

        // square-and-multiply, non-positive exponent gives one
        function longint unsigned power_mod(longint unsigned base, longint e,
                                            longint unsigned m);
            longint unsigned res, n;
            res = 1 % m;
            if (e <= 0)
                return res;
            n = e;
            while (n > 0)
            begin
                if ((n & 1) != 0)
                    res = res * base % m;
                base = base * base % m;
                n    = n >> 1;
            end
            return res;
        endfunction

        function logic [VALUE_W-1:0] modular_result(logic [KIND_W-1:0] kind,
                                                    logic [OPA_W-1:0] a_raw,
                                                    logic [OPB_W-1:0] b_raw);
            longint unsigned m, a, br, r, res;
            longint          bs;
            m   = modulus;
            bs  = longint'($signed(b_raw));
            res = 0;
            if (m == 0)
                return '0;
            a = longint'(a_raw) % m;
            // signed operand into 0 .. m-1
            if (bs >= 0)
                br = longint'(bs) % m;
            else
            begin
                r  = longint'(-bs) % m;
                br = (r != 0) ? m - r : 0;
            end
            case (kind)
                mau_pkg::KIND_ADD: res = (a + br) % m;
                mau_pkg::KIND_SUB: res = (a + m - br) % m;
                mau_pkg::KIND_MUL: res = a * br % m;
                mau_pkg::KIND_DIV: res = a * longint'(inverse_coeff(br, m)) % m;
                mau_pkg::KIND_POW: res = power_mod(a, bs, m);
                default:           res = 0;
            endcase
            return res[VALUE_W-1:0];
        endfunction

        function void take_operation(logic [KIND_W-1:0] kind, logic [OPA_W-1:0] a,
                                     logic [OPB_W-1:0] b);
            op_record_t rec;
            rec.kind  = kind;
            rec.a     = a;
            rec.b     = b;
            rec.value = modular_result(kind, a, b);
            expected_q.push_back(rec);
        endfunction

        function void check_value(logic [VALUE_W-1:0] got);
            op_record_t rec;
            if (expected_q.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected result beat: value %h", got);
                errors++;
                return;
            end
            rec = expected_q.pop_front();
            if (got !== rec.value)
            begin
                if (errors < 10)
                    $display("value error: kind %0d a %h b %h mod %h expected %h got %h",
                             rec.kind, rec.a, rec.b, modulus, rec.value, got);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata;
    logic [KIND_W-1:0]    s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [VALUE_W-1:0]   m_axis_tdata;

    residue_board         board;
    logic [CFG_W-1:0]     cur_mod;
    logic [CFG_W-1:0]     phase_mod [PHASES];
    int                   phase_len [PHASES];
    int                   burst_left;
    int                   quiet_cycles;
    logic [15:0]          stall_pat;
    int                   pat_age;

    modular_arithmetic_unit #(
        .WIDTH(32)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // record accepted beats on both sides
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.take_operation(s_axis_tuser, s_axis_tdata[OPA_W-1:0],
                                     s_axis_tdata[OPA_W +: OPB_W]);
            if (m_axis_tvalid && m_axis_tready)
                board.check_value(m_axis_tdata);
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver backpressure from a rotating pattern, renewed now and then
    always @(negedge clk)
    begin
        m_axis_tready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
        pat_age++;
        if (pat_age >= 200)
        begin
            pat_age = 0;
            if ($urandom_range(0, 3) == 0)
                stall_pat = '1;
            else
                stall_pat = 16'($urandom()) | 16'h0001;
        end
    end

    // present one beat and hold it until accepted
    task automatic send_beat(logic [KIND_W-1:0] kind, logic [OPA_W-1:0] a,
                             logic [OPB_W-1:0] b);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{PAD_W{1'b0}}, b, a};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // valid low with junk on the bus; n sets how long
    task automatic idle(int n);
        repeat (n)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tuser  <= KIND_W'($urandom());
            s_axis_tdata  <= TDATA_W'({$urandom(), $urandom(), $urandom()});
        end
    endtask

    // bursts of beats separated by random gaps
    task automatic pace();
        burst_left--;
        if (burst_left <= 0)
        begin
            if ($urandom_range(0, 9) == 0)
                idle($urandom_range(40, 150));
            else
                idle($urandom_range(0, 12));
            burst_left = $urandom_range(1, 10);
        end
    endtask

    // stop sending until every expected value has come back
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_modulus(logic [CFG_W-1:0] m);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(negedge clk);
        cfg_we   <= 1'b0;
        board.set_modulus(m);
        cur_mod = m;
    endtask

    task automatic random_phase(int count);
        logic [KIND_W-1:0] kind;
        logic [OPA_W-1:0]  a;
        logic [OPB_W-1:0]  b;
        longint            prod;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
            else
                kind = KIND_W'($urandom_range(mau_pkg::KIND_ADD, mau_pkg::KIND_POW));
            // left operand: mostly reduced, sometimes unreduced or at the edges
            case ($urandom_range(0, 9))
                0: a = $urandom();
                1: a = '0;
                2: a = (cur_mod != 0) ? cur_mod - 1 : $urandom();
                default: a = (cur_mod != 0) ? $urandom() % cur_mod : $urandom();
            endcase
            // right operand or exponent
            case ($urandom_range(0, 9))
                0, 1, 2: b = {1'($urandom_range(0, 1)), 32'($urandom())};
                3, 4:    b = 33'($urandom_range(0, 40)) - 33'd20;
                5, 6:    b = (cur_mod != 0) ? 33'($urandom() % cur_mod) : 33'($urandom());
                7:
                begin
                    prod = longint'(cur_mod) * (int'($urandom_range(0, 4)) - 2)
                           + (int'($urandom_range(0, 2)) - 1);
                    b = prod[OPB_W-1:0];
                end
                8:
                begin
                    case ($urandom_range(0, 3))
                        0: b = 33'h0_FFFF_FFFF;
                        1: b = 33'h1_0000_0000;
                        2: b = '1;
                        default: b = '0;
                    endcase
                end
                default: b = -((cur_mod != 0) ? 33'($urandom() % cur_mod) : 33'($urandom()));
            endcase
            send_beat(kind, a, b);
            pace();
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = mau_pkg::KIND_ADD;
        m_axis_tready = 1'b1;
        stall_pat     = 16'hFFFF;
        pat_age       = 0;
        quiet_cycles  = 0;
        burst_left    = 4;
        cur_mod       = mau_pkg::MOD_RESET_VAL;
        board         = new();

        // moduli of the later phases: small prime, power of two, all ones, the smallest prime,
        // one and zero, composite, largest prime, random
        phase_mod = '{32'd97, 32'd65536, 32'hFFFF_FFFF, 32'd2, 32'd1, 32'd0,
                      32'd1000000000, 32'd4294967291, $urandom_range(3, 32'hFFFF_FFFF)};
        phase_len = '{30, 25, 30, 25, 10, 10, 30, 30, 30};

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed beats under the reset modulus
        send_beat(mau_pkg::KIND_ADD, 32'd0, 33'd0);
        send_beat(mau_pkg::KIND_ADD, mau_pkg::MOD_RESET_VAL - 32'd1,
                  {1'b0, mau_pkg::MOD_RESET_VAL - 32'd1});
        send_beat(mau_pkg::KIND_ADD, 32'hFFFF_FFFF, 33'h0_FFFF_FFFF);
        send_beat(mau_pkg::KIND_ADD, 32'h8000_0000, 33'h1_0000_0000);
        send_beat(mau_pkg::KIND_SUB, 32'd0, 33'd1);
        send_beat(mau_pkg::KIND_SUB, 32'd5, -33'd7);
        pace();
        send_beat(mau_pkg::KIND_SUB, mau_pkg::MOD_RESET_VAL - 32'd1, -33'd1);
        send_beat(mau_pkg::KIND_MUL, mau_pkg::MOD_RESET_VAL - 32'd1,
                  {1'b0, mau_pkg::MOD_RESET_VAL - 32'd1});
        send_beat(mau_pkg::KIND_MUL, 32'hFFFF_FFFF, 33'h1_0000_0000);
        // zero divisor, divisor equal to the modulus, plain and negative divisors
        send_beat(mau_pkg::KIND_DIV, 32'd12345, 33'd0);
        send_beat(mau_pkg::KIND_DIV, 32'd777, {1'b0, mau_pkg::MOD_RESET_VAL});
        send_beat(mau_pkg::KIND_DIV, 32'd1, 33'd2);
        pace();
        send_beat(mau_pkg::KIND_DIV, mau_pkg::MOD_RESET_VAL - 32'd1, -33'd1);
        send_beat(mau_pkg::KIND_DIV, 32'hFFFF_FFFF, 33'h0_FFFF_FFFF);
        // zero and negative exponents, zero base, largest exponent, fermat
        send_beat(mau_pkg::KIND_POW, 32'd3, 33'd0);
        send_beat(mau_pkg::KIND_POW, 32'd3, -33'd5);
        send_beat(mau_pkg::KIND_POW, 32'd0, 33'd5);
        send_beat(mau_pkg::KIND_POW, 32'd2, 33'd1);
        pace();
        send_beat(mau_pkg::KIND_POW, 32'hFFFF_FFFF, 33'h0_FFFF_FFFF);
        send_beat(mau_pkg::KIND_POW, 32'd2, {1'b0, mau_pkg::MOD_RESET_VAL - 32'd1});
        for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++)
            send_beat(KIND_W'(k), $urandom(), {1'($urandom_range(0, 1)), 32'($urandom())});
        random_phase(25);

        for (int p = 0; p < PHASES; p++)
        begin
            write_modulus(phase_mod[p]);
            // divisors sharing a factor with the composite modulus
            if (phase_mod[p] == 32'd1000000000)
            begin
                send_beat(mau_pkg::KIND_DIV, 32'd7, 33'd2);
                send_beat(mau_pkg::KIND_DIV, 32'd999, -33'd250);
            end
            random_phase(phase_len[p]);
        end

        drain_results();
        repeat (20)
            @(negedge clk);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
